// ===== rtl/dpsi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dyadic patch support intersection: shared types and helpers
// Rectangle layout, per-lane result, shift amounts and the saturating shift.
// ----------------------------------------------------------------------------
package dpsi_pkg;

  localparam int NUM_RECT    = 3;
  localparam int LEVEL_W     = 4;
  localparam int COORD_W     = 16;
  localparam int CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LEVEL_X = 3'd0,
    REG_LEVEL_Y = 3'd1,
    REG_PRESENT = 3'd2,
    REG_RECT0   = 3'd3,
    REG_RECT1   = 3'd4,
    REG_RECT2   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_W-1:0] ymax;
    logic [COORD_W-1:0] ymin;
    logic [COORD_W-1:0] xmax;
    logic [COORD_W-1:0] xmin;
  } rect_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] common_x;
    logic [LEVEL_W-1:0] common_y;
    logic [LEVEL_W-1:0] ref_x;
    logic [LEVEL_W-1:0] ref_y;
    logic [LEVEL_W-1:0] cand_x;
    logic [LEVEL_W-1:0] cand_y;
  } shift_t;

  typedef struct packed {
    logic  found;
    rect_t rect;
  } lane_result_t;

  function automatic logic [COORD_W-1:0] shl_sat(logic [COORD_W-1:0] v,
                                                  logic [LEVEL_W-1:0] sh);
    logic [COORD_W+14:0] w;
    w = {15'd0, v} << sh;
    return (|w[COORD_W+14:COORD_W]) ? {COORD_W{1'b1}} : w[COORD_W-1:0];
  endfunction

  function automatic rect_t shift_rect(rect_t r, logic [LEVEL_W-1:0] sx,
                                       logic [LEVEL_W-1:0] sy);
    rect_t s;
    s.xmin = shl_sat(r.xmin, sx);
    s.xmax = shl_sat(r.xmax, sx);
    s.ymin = shl_sat(r.ymin, sy);
    s.ymax = shl_sat(r.ymax, sy);
    return s;
  endfunction

endpackage

// ===== rtl/dpsi_level.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Level alignment
// Clamps both level pairs, picks the common level and derives the shifts.
// ----------------------------------------------------------------------------
module dpsi_level #(
  parameter int MAX_LEVEL = 15
) (
  input  logic [dpsi_pkg::LEVEL_W-1:0] ref_level_x,
  input  logic [dpsi_pkg::LEVEL_W-1:0] ref_level_y,
  input  logic [dpsi_pkg::LEVEL_W-1:0] cand_level_x,
  input  logic [dpsi_pkg::LEVEL_W-1:0] cand_level_y,
  output dpsi_pkg::shift_t             shifts
);
  import dpsi_pkg::*;

  logic [LEVEL_W-1:0] rlx, rly, clx, cly;

  function automatic logic [LEVEL_W-1:0] clamp(logic [LEVEL_W-1:0] lv);
    return (32'(lv) > MAX_LEVEL) ? LEVEL_W'(MAX_LEVEL) : lv;
  endfunction

  always_comb begin
    rlx = clamp(ref_level_x);
    rly = clamp(ref_level_y);
    clx = clamp(cand_level_x);
    cly = clamp(cand_level_y);
    shifts.common_x = (rlx > clx) ? rlx : clx;
    shifts.common_y = (rly > cly) ? rly : cly;
    shifts.ref_x    = shifts.common_x - rlx;
    shifts.ref_y    = shifts.common_y - rly;
    shifts.cand_x   = shifts.common_x - clx;
    shifts.cand_y   = shifts.common_y - cly;
  end

endmodule

// ===== rtl/dpsi_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Patch lane
// Shifts both rectangles to the common level, then tests for open overlap
// and forms the clipped rectangle. Two register stages.
// ----------------------------------------------------------------------------
module dpsi_lane (
  input  logic                   clk,
  input  logic                   active,
  input  dpsi_pkg::rect_t        ref_rect,
  input  dpsi_pkg::rect_t        cand_rect,
  input  dpsi_pkg::shift_t       shifts,
  output dpsi_pkg::lane_result_t result
);
  import dpsi_pkg::*;

  rect_t        a, b;
  logic         active_q;
  logic         overlap;
  rect_t        clip;

  always_ff @(posedge clk) begin
    a        <= shift_rect(ref_rect, shifts.ref_x, shifts.ref_y);
    b        <= shift_rect(cand_rect, shifts.cand_x, shifts.cand_y);
    active_q <= active;
  end

  always_comb begin
    overlap = active_q && (a.xmin < b.xmax) && (a.xmax > b.xmin)
                       && (a.ymin < b.ymax) && (a.ymax > b.ymin);
    clip.xmin = (a.xmin > b.xmin) ? a.xmin : b.xmin;
    clip.xmax = (a.xmax < b.xmax) ? a.xmax : b.xmax;
    clip.ymin = (a.ymin > b.ymin) ? a.ymin : b.ymin;
    clip.ymax = (a.ymax < b.ymax) ? a.ymax : b.ymax;
  end

  always_ff @(posedge clk) begin
    result.found <= overlap;
    result.rect  <= overlap ? clip : '0;
  end

endmodule

// ===== rtl/dpsi_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lane merge
// Gathers the lane results into the overlap mask and the hit flag and
// registers the complete result.
// ----------------------------------------------------------------------------
module dpsi_merge (
  input  logic                              clk,
  input  dpsi_pkg::lane_result_t            lanes [dpsi_pkg::NUM_RECT],
  input  logic [15:0]                       index_in,
  input  logic [dpsi_pkg::LEVEL_W-1:0]      level_x_in,
  input  logic [dpsi_pkg::LEVEL_W-1:0]      level_y_in,
  output logic [15:0]                       out_index,
  output logic                              hit,
  output logic [dpsi_pkg::LEVEL_W-1:0]      common_level_x,
  output logic [dpsi_pkg::LEVEL_W-1:0]      common_level_y,
  output logic [dpsi_pkg::NUM_RECT-1:0]     overlap_present,
  output dpsi_pkg::rect_t                   overlap_rect [dpsi_pkg::NUM_RECT]
);
  import dpsi_pkg::*;

  logic [NUM_RECT-1:0] mask;

  always_comb begin
    for (int p = 0; p < NUM_RECT; p++) begin
      mask[p] = lanes[p].found;
    end
  end

  always_ff @(posedge clk) begin
    out_index       <= index_in;
    hit             <= |mask;
    common_level_x  <= level_x_in;
    common_level_y  <= level_y_in;
    overlap_present <= mask;
    for (int p = 0; p < NUM_RECT; p++) begin
      overlap_rect[p] <= lanes[p].rect;
    end
  end

endmodule

// ===== rtl/dyadic_patch_support_intersect_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dyadic patch support intersection unit
// Compares each candidate support with the configured reference support and
// reports the common levels, the per-patch overlap mask and clipped rectangles.
// ----------------------------------------------------------------------------
// Channel   Signals                                   Transfer condition
// command   start, busy, cand_*                       start && !busy
// result    done, out_index, hit, common_level_*,     done (one cycle)
//           overlap_present, overlap_rect*
// config    cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid && cfg_ready
//
// One candidate is accepted every cycle; busy is always low.
// Each result passes through three register stages after its command: the
// level shifts, the overlap compares in the patch lanes, and the merge.
// Synchronous reset clears the reference registers and the valid pipeline.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module dyadic_patch_support_intersect_unit #(
  parameter int MAX_LEVEL   = 15,
  parameter int NUM_PATCHES = 3
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [15:0]                        cand_index,
  input  logic [dpsi_pkg::LEVEL_W-1:0]       cand_level_x,
  input  logic [dpsi_pkg::LEVEL_W-1:0]       cand_level_y,
  input  logic [dpsi_pkg::NUM_RECT-1:0]      cand_present,
  input  logic [63:0]                        cand_rect0,
  input  logic [63:0]                        cand_rect1,
  input  logic [63:0]                        cand_rect2,
  output logic                               done,
  output logic [15:0]                        out_index,
  output logic                               hit,
  output logic [dpsi_pkg::LEVEL_W-1:0]       common_level_x,
  output logic [dpsi_pkg::LEVEL_W-1:0]       common_level_y,
  output logic [dpsi_pkg::NUM_RECT-1:0]      overlap_present,
  output logic [63:0]                        overlap_rect0,
  output logic [63:0]                        overlap_rect1,
  output logic [63:0]                        overlap_rect2,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dpsi_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [63:0]                        cfg_data
);
  import dpsi_pkg::*;

  logic [LEVEL_W-1:0]  ref_level_x, ref_level_y;
  logic [NUM_RECT-1:0] ref_present;
  rect_t               ref_rect [NUM_RECT];
  rect_t               cand_rect [NUM_RECT];
  rect_t               ov_rect [NUM_RECT];
  lane_result_t        lanes [NUM_RECT];
  shift_t              shifts;
  logic [2:0]          valid;
  logic [15:0]         index1, index2;
  logic [LEVEL_W-1:0]  lx1, ly1, lx2, ly2;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign done      = valid[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_level_x <= '0;
      ref_level_y <= '0;
      ref_present <= '0;
      for (int p = 0; p < NUM_RECT; p++) begin
        ref_rect[p] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_LEVEL_X: ref_level_x <= cfg_data[LEVEL_W-1:0];
        REG_LEVEL_Y: ref_level_y <= cfg_data[LEVEL_W-1:0];
        REG_PRESENT: ref_present <= cfg_data[NUM_RECT-1:0];
        REG_RECT0:   ref_rect[0] <= rect_t'(cfg_data);
        REG_RECT1:   ref_rect[1] <= rect_t'(cfg_data);
        REG_RECT2:   ref_rect[2] <= rect_t'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[1:0], start && !busy};
    end
  end

  always_ff @(posedge clk) begin
    index1 <= cand_index;
    index2 <= index1;
    lx1    <= shifts.common_x;
    ly1    <= shifts.common_y;
    lx2    <= lx1;
    ly2    <= ly1;
  end

  assign cand_rect[0] = rect_t'(cand_rect0);
  assign cand_rect[1] = rect_t'(cand_rect1);
  assign cand_rect[2] = rect_t'(cand_rect2);

  dpsi_level #(
    .MAX_LEVEL(MAX_LEVEL)
  ) u_level (
    .ref_level_x (ref_level_x),
    .ref_level_y (ref_level_y),
    .cand_level_x(cand_level_x),
    .cand_level_y(cand_level_y),
    .shifts      (shifts)
  );

  for (genvar p = 0; p < NUM_RECT; p++) begin : g_lane
    localparam bit LaneOn = (p < NUM_PATCHES);
    dpsi_lane u_lane (
      .clk      (clk),
      .active   (LaneOn && ref_present[p] && cand_present[p]),
      .ref_rect (ref_rect[p]),
      .cand_rect(cand_rect[p]),
      .shifts   (shifts),
      .result   (lanes[p])
    );
  end

  dpsi_merge u_merge (
    .clk            (clk),
    .lanes          (lanes),
    .index_in       (index2),
    .level_x_in     (lx2),
    .level_y_in     (ly2),
    .out_index      (out_index),
    .hit            (hit),
    .common_level_x (common_level_x),
    .common_level_y (common_level_y),
    .overlap_present(overlap_present),
    .overlap_rect   (ov_rect)
  );

  assign overlap_rect0 = ov_rect[0];
  assign overlap_rect1 = ov_rect[1];
  assign overlap_rect2 = ov_rect[2];

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 3))
    else $error("result without a command three cycles earlier");

  a_index_echo: assert property (@(posedge clk) disable iff (rst)
    done |-> out_index == $past(cand_index, 3))
    else $error("echoed index does not match its command");

  a_hit_mask: assert property (@(posedge clk) disable iff (rst)
    done |-> hit == (overlap_present != '0))
    else $error("hit flag disagrees with overlap mask");

  a_absent_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !overlap_present[0]) |-> overlap_rect0 == '0)
    else $error("patch 0 rectangle nonzero without overlap");

endmodule

// ===== verif/tb_dyadic_patch_support_intersect_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the dyadic patch support intersection unit
// Loads a series of reference supports through the register channel, sends
// directed and random candidate supports and checks every result against a
// predicted common level, overlap mask and clipped rectangles per patch.
// ----------------------------------------------------------------------------
module tb_dyadic_patch_support_intersect_unit;
  import dpsi_pkg::*;

  localparam int MAX_LEVEL    = 15;
  localparam int NUM_PATCHES  = 3;
  localparam int LATENCY      = 3;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPORT_LIMIT = 10;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [15:0]                index;
    logic [LEVEL_W-1:0]         level_x;
    logic [LEVEL_W-1:0]         level_y;
    logic [NUM_RECT-1:0]        present;
    rect_t [NUM_RECT-1:0]       rect;
  } cand_t;

  typedef struct packed {
    logic [15:0]                index;
    logic                       hit;
    logic [LEVEL_W-1:0]         level_x;
    logic [LEVEL_W-1:0]         level_y;
    logic [NUM_RECT-1:0]        present;
    rect_t [NUM_RECT-1:0]       rect;
  } overlap_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]         level_x;
    logic [LEVEL_W-1:0]         level_y;
    logic [NUM_RECT-1:0]        present;
    rect_t [NUM_RECT-1:0]       rect;
  } reference_t;

  class overlap_checker;
    logic [LEVEL_W-1:0]  ref_lx;
    logic [LEVEL_W-1:0]  ref_ly;
    logic [NUM_RECT-1:0] ref_pres;
    rect_t               ref_rect [NUM_RECT];
    overlap_t            pending_overlaps [$];
    int                  checked;
    int                  mismatches;
    int                  hits;
    int                  patch_hits [NUM_RECT];

    function new();
      ref_lx = '0;
      ref_ly = '0;
      ref_pres = '0;
      hits = 0;
      checked = 0;
      mismatches = 0;
      for (int i = 0; i < NUM_RECT; i++) begin
        ref_rect[i] = '0;
        patch_hits[i] = 0;
      end
    endfunction

    function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [63:0] data);
      case (idx)
        REG_LEVEL_X: ref_lx = data[LEVEL_W-1:0];
        REG_LEVEL_Y: ref_ly = data[LEVEL_W-1:0];
        REG_PRESENT: ref_pres = data[NUM_RECT-1:0];
        REG_RECT0:   ref_rect[0] = data;
        REG_RECT1:   ref_rect[1] = data;
        REG_RECT2:   ref_rect[2] = data;
        default: ;
      endcase
    endfunction

    function logic [LEVEL_W-1:0] clamp_level(logic [LEVEL_W-1:0] lv);
      return (lv > MAX_LEVEL) ? LEVEL_W'(MAX_LEVEL) : lv;
    endfunction

    // Moves a coordinate to a finer level, pinning it at the top of the range.
    function logic [15:0] scale_coord(logic [15:0] v, logic [LEVEL_W-1:0] sh);
      logic [31:0] w;
      w = {16'd0, v} << sh;
      return (w > 32'd65535) ? 16'hFFFF : w[15:0];
    endfunction

    function overlap_t predict_result(cand_t c);
      overlap_t           r;
      logic [LEVEL_W-1:0] rlx, rly, clx, cly, lx, ly;
      rect_t              a, b;
      rlx = clamp_level(ref_lx);
      rly = clamp_level(ref_ly);
      clx = clamp_level(c.level_x);
      cly = clamp_level(c.level_y);
      lx = (rlx > clx) ? rlx : clx;
      ly = (rly > cly) ? rly : cly;
      r = '0;
      r.index = c.index;
      r.level_x = lx;
      r.level_y = ly;
      for (int p = 0; p < NUM_RECT && p < NUM_PATCHES; p++) begin
        if (ref_pres[p] && c.present[p]) begin
          a.xmin = scale_coord(ref_rect[p].xmin, lx - rlx);
          a.xmax = scale_coord(ref_rect[p].xmax, lx - rlx);
          a.ymin = scale_coord(ref_rect[p].ymin, ly - rly);
          a.ymax = scale_coord(ref_rect[p].ymax, ly - rly);
          b.xmin = scale_coord(c.rect[p].xmin, lx - clx);
          b.xmax = scale_coord(c.rect[p].xmax, lx - clx);
          b.ymin = scale_coord(c.rect[p].ymin, ly - cly);
          b.ymax = scale_coord(c.rect[p].ymax, ly - cly);
          if (a.xmin < b.xmax && a.xmax > b.xmin && a.ymin < b.ymax && a.ymax > b.ymin) begin
            r.present[p] = 1'b1;
            r.rect[p].xmin = (a.xmin > b.xmin) ? a.xmin : b.xmin;
            r.rect[p].xmax = (a.xmax < b.xmax) ? a.xmax : b.xmax;
            r.rect[p].ymin = (a.ymin > b.ymin) ? a.ymin : b.ymin;
            r.rect[p].ymax = (a.ymax < b.ymax) ? a.ymax : b.ymax;
          end
        end
      end
      r.hit = |r.present;
      return r;
    endfunction

    function void note_candidate(cand_t c);
      overlap_t e;
      e = predict_result(c);
      pending_overlaps = {pending_overlaps, e};
      if (e.hit) hits++;
      for (int p = 0; p < NUM_RECT; p++)
        if (e.present[p]) patch_hits[p]++;
    endfunction

    function void compare_field(string name, logic [15:0] idx, logic [63:0] want,
                                logic [63:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("Mismatch on %s for candidate %0d: expected %h, got %h",
                   name, idx, want, got);
      end
    endfunction

    function void check_overlap(overlap_t got);
      overlap_t want;
      if (pending_overlaps.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("Result for candidate %0d arrived with nothing outstanding", got.index);
        return;
      end
      want = pending_overlaps.pop_front();
      checked++;
      compare_field("out_index", want.index, want.index, got.index);
      compare_field("hit", want.index, want.hit, got.hit);
      compare_field("common_level_x", want.index, want.level_x, got.level_x);
      compare_field("common_level_y", want.index, want.level_y, got.level_y);
      compare_field("overlap_present", want.index, want.present, got.present);
      compare_field("overlap_rect0", want.index, want.rect[0], got.rect[0]);
      compare_field("overlap_rect1", want.index, want.rect[1], got.rect[1]);
      compare_field("overlap_rect2", want.index, want.rect[2], got.rect[2]);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  logic [15:0]            cand_index = '0;
  logic [LEVEL_W-1:0]     cand_level_x = '0;
  logic [LEVEL_W-1:0]     cand_level_y = '0;
  logic [NUM_RECT-1:0]    cand_present = '0;
  logic [63:0]            cand_rect0 = '0;
  logic [63:0]            cand_rect1 = '0;
  logic [63:0]            cand_rect2 = '0;
  logic                   done;
  logic [15:0]            out_index;
  logic                   hit;
  logic [LEVEL_W-1:0]     common_level_x;
  logic [LEVEL_W-1:0]     common_level_y;
  logic [NUM_RECT-1:0]    overlap_present;
  logic [63:0]            overlap_rect0;
  logic [63:0]            overlap_rect1;
  logic [63:0]            overlap_rect2;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [63:0]            cfg_data = '0;

  overlap_checker board = new();
  int                     cycles = 0;
  int                     sent = 0;
  int                     writes = 0;
  int                     settings = 0;
  bit                     steady = 1'b0;

  dyadic_patch_support_intersect_unit #(
    .MAX_LEVEL  (MAX_LEVEL),
    .NUM_PATCHES(NUM_PATCHES)
  ) u_dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d results outstanding",
               board.pending_overlaps.size());
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin : monitor
    overlap_t got;
    cand_t    seen;
    if (!rst) begin
      if (done !== 1'b0) begin
        got.index = out_index;
        got.hit = hit;
        got.level_x = common_level_x;
        got.level_y = common_level_y;
        got.present = overlap_present;
        got.rect = {rect_t'(overlap_rect2), rect_t'(overlap_rect1), rect_t'(overlap_rect0)};
        board.check_overlap(got);
      end
      if (start && busy === 1'b0) begin
        seen.index = cand_index;
        seen.level_x = cand_level_x;
        seen.level_y = cand_level_y;
        seen.present = cand_present;
        seen.rect = {rect_t'(cand_rect2), rect_t'(cand_rect1), rect_t'(cand_rect0)};
        board.note_candidate(seen);
      end
      if (cfg_valid && cfg_ready === 1'b1)
        board.write_register(cfg_index, cfg_data);
    end
  end

  function automatic rect_t box(logic [15:0] xn, logic [15:0] xx, logic [15:0] yn,
                                logic [15:0] yx);
    rect_t r;
    r.xmin = xn;
    r.xmax = xx;
    r.ymin = yn;
    r.ymax = yx;
    return r;
  endfunction

  function automatic cand_t make_cand(logic [15:0] idx, int lx, int ly, logic [2:0] pres,
                                      rect_t r0, rect_t r1, rect_t r2);
    cand_t c;
    c.index = idx;
    c.level_x = LEVEL_W'(lx);
    c.level_y = LEVEL_W'(ly);
    c.present = pres;
    c.rect = {r2, r1, r0};
    return c;
  endfunction

  function automatic rect_t reference_rect();
    rect_t r;
    int    pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      r.xmin = 16'($urandom_range(0, 4000));
      r.xmax = r.xmin + 16'($urandom_range(1, 4000));
      r.ymin = 16'($urandom_range(0, 4000));
      r.ymax = r.ymin + 16'($urandom_range(1, 4000));
    end else if (pick < 88) begin
      r = {$urandom, $urandom};
    end else if (pick < 94) begin
      r = box(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
    end else begin
      r = box(16'($urandom_range(2000, 4000)), 16'($urandom_range(0, 1999)),
              16'($urandom_range(2000, 4000)), 16'($urandom_range(0, 1999)));
    end
    return r;
  endfunction

  function automatic reference_t random_reference();
    reference_t s;
    s.level_x = LEVEL_W'($urandom_range(0, 15));
    s.level_y = LEVEL_W'($urandom_range(0, 15));
    s.present = ($urandom_range(0, 99) < 60) ? 3'b111 : 3'($urandom);
    for (int p = 0; p < NUM_RECT; p++)
      s.rect[p] = reference_rect();
    return s;
  endfunction

  function automatic logic [LEVEL_W-1:0] near_level(logic [LEVEL_W-1:0] lv);
    int v;
    if ($urandom_range(0, 99) < 30) return LEVEL_W'($urandom_range(0, 15));
    v = int'(lv) + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 15) v = 15;
    return LEVEL_W'(v);
  endfunction

  function automatic logic [15:0] move_coord(logic [15:0] v, int from_lv, int to_lv);
    longint w;
    w = longint'(v);
    if (to_lv >= from_lv) w = w << (to_lv - from_lv);
    else w = w >> (from_lv - to_lv);
    w = w + longint'($urandom_range(0, 16)) - 8;
    if (w < 0) w = 0;
    if (w > 65535) w = 65535;
    return w[15:0];
  endfunction

  // Builds a candidate rectangle roughly covering the reference one, seen at
  // the candidate's own levels, so that most candidates land near an overlap.
  function automatic rect_t near_rect(rect_t r, int fx, int tx, int fy, int ty);
    rect_t o;
    o.xmin = move_coord(r.xmin, fx, tx);
    o.xmax = move_coord(r.xmax, fx, tx);
    o.ymin = move_coord(r.ymin, fy, ty);
    o.ymax = move_coord(r.ymax, fy, ty);
    return o;
  endfunction

  function automatic cand_t random_candidate(reference_t s);
    cand_t c;
    c.index = 16'($urandom);
    c.level_x = near_level(s.level_x);
    c.level_y = near_level(s.level_y);
    c.present = 3'($urandom);
    if ($urandom_range(0, 99) < 80) begin
      if ($urandom_range(0, 3) == 0) c.present = 3'b111;
      for (int p = 0; p < NUM_RECT; p++)
        c.rect[p] = ($urandom_range(0, 9) == 0) ? rect_t'({$urandom, $urandom}) :
                    near_rect(s.rect[p], s.level_x, c.level_x, s.level_y, c.level_y);
    end else begin
      for (int p = 0; p < NUM_RECT; p++)
        c.rect[p] = {$urandom, $urandom};
    end
    return c;
  endfunction

  task automatic send_candidate(cand_t c);
    if (!steady && $urandom_range(0, 99) < 15) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    cand_index <= c.index;
    cand_level_x <= c.level_x;
    cand_level_y <= c.level_y;
    cand_present <= c.present;
    cand_rect0 <= c.rect[0];
    cand_rect1 <= c.rect[1];
    cand_rect2 <= c.rect[2];
    do @(posedge clk); while (busy !== 1'b0);
    sent++;
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [63:0] data);
    if (!steady && $urandom_range(0, 99) < 15) begin
      cfg_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    writes++;
  endtask

  task automatic settle();
    start <= 1'b0;
    cfg_valid <= 1'b0;
    while (board.pending_overlaps.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // Unused upper bits of the level and mask registers carry random data,
  // which the block must drop.
  task automatic load_reference(reference_t s, bit spare);
    settle();
    write_reg(REG_LEVEL_X, {32'($urandom), 28'($urandom), s.level_x});
    write_reg(REG_LEVEL_Y, {32'($urandom), 28'($urandom), s.level_y});
    write_reg(REG_PRESENT, {32'($urandom), 29'($urandom), s.present});
    write_reg(REG_RECT0, s.rect[0]);
    write_reg(REG_RECT1, s.rect[1]);
    write_reg(REG_RECT2, s.rect[2]);
    if (spare) begin
      write_reg(REG_SPARE_6, {$urandom, $urandom});
      write_reg(REG_SPARE_7, {$urandom, $urandom});
    end
    cfg_valid <= 1'b0;
    settings++;
  endtask

  initial begin : stimulus
    reference_t s;
    cand_t      d;
    int         failed;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_candidate(make_cand(16'h0100, 15, 0, 3'b111, box(0, 16'hFFFF, 0, 16'hFFFF),
                             box(1, 2, 1, 2), box(0, 9, 0, 9)));
    send_candidate(make_cand(16'h0101, 0, 15, 3'b011, '1, '0, '1));
    send_candidate(make_cand(16'h0102, 7, 9, 3'b101, box(3, 8, 3, 8), '0, '0));
    settings++;

    s.level_x = 4'd3;
    s.level_y = 4'd5;
    s.present = 3'b111;
    s.rect[0] = box(10, 20, 100, 200);
    s.rect[1] = box(0, 16'hFFFF, 0, 16'hFFFF);
    s.rect[2] = box(50, 10, 300, 200);
    load_reference(s, 1'b1);

    d = make_cand(16'h0000, 3, 5, 3'b111, box(15, 30, 150, 250), box(100, 200, 100, 200),
                  box(0, 100, 0, 400));
    send_candidate(d);
    send_candidate(make_cand(16'hFFFF, 3, 5, 3'b001, box(20, 40, 100, 200), '0, '0));
    send_candidate(make_cand(16'h0001, 3, 5, 3'b001, box(0, 10, 150, 160), '0, '0));
    send_candidate(make_cand(16'h0002, 3, 5, 3'b001, box(12, 18, 200, 300), '0, '0));
    send_candidate(make_cand(16'h0003, 0, 0, 3'b111, box(1, 3, 3, 7), box(0, 1, 0, 1),
                             box(6, 7, 0, 9)));
    send_candidate(make_cand(16'h0004, 15, 15, 3'b111, box(0, 16'hFFFF, 0, 16'hFFFF),
                             box(0, 16'hFFFF, 0, 16'hFFFF), box(0, 16'hFFFF, 0, 16'hFFFF)));
    send_candidate(make_cand(16'h0005, 15, 0, 3'b011, box(40000, 50000, 3, 7),
                             box(1, 2, 1, 2), '0));
    send_candidate(make_cand(16'h0006, 0, 15, 3'b101, box(1, 2, 30000, 60000), '0,
                             box(0, 16'hFFFF, 0, 16'hFFFF)));
    send_candidate(make_cand(16'h0007, 3, 5, 3'b000, box(15, 30, 150, 250),
                             box(0, 16'hFFFF, 0, 16'hFFFF), box(0, 100, 0, 400)));
    send_candidate(make_cand(16'h0008, 3, 5, 3'b010, box(15, 30, 150, 250),
                             box(5, 6, 5, 6), '0));
    send_candidate(make_cand(16'h0009, 3, 5, 3'b100, '0, '0, box(5, 60, 100, 350)));
    send_candidate(make_cand(16'h000A, 3, 5, 3'b111, '0, '0, '0));
    send_candidate(make_cand(16'h000B, 3, 5, 3'b111, '1, '1, '1));
    send_candidate(make_cand(16'h000C, 3, 5, 3'b111, box(30, 15, 250, 150),
                             box(9, 3, 9, 3), box(40, 20, 280, 220)));
    send_candidate(make_cand(16'h000D, 8, 2, 3'b111, {$urandom, $urandom},
                             {$urandom, $urandom}, {$urandom, $urandom}));
    send_candidate(make_cand(16'h000E, 15, 15, 3'b111, box(0, 1, 0, 1),
                             box(65534, 16'hFFFF, 65534, 16'hFFFF), box(0, 1, 0, 1)));

    // Writes to the unused indexes must leave the reference untouched.
    settle();
    write_reg(REG_SPARE_6, '1);
    write_reg(REG_SPARE_7, '0);
    cfg_valid <= 1'b0;
    d.index = 16'h0010;
    send_candidate(d);

    for (int ph = 0; ph < 8; ph++) begin
      s = random_reference();
      case (ph)
        0: begin s.level_x = 4'd0;  s.level_y = 4'd0;  end
        1: begin s.level_x = 4'd15; s.level_y = 4'd15; end
        2: begin s.level_x = 4'd0;  s.level_y = 4'd15; end
        3: begin s.level_x = 4'd15; s.level_y = 4'd0;  end
        4: s.present = 3'b000;
        5: for (int p = 0; p < NUM_RECT; p++) s.rect[p] = {$urandom, $urandom};
        default: ;
      endcase
      load_reference(s, ph[0]);
      steady = (ph == 6);
      for (int i = 0; i < ((ph == 4) ? 40 : 160); i++)
        send_candidate(random_candidate(s));
    end
    steady = 1'b0;
    settle();

    failed = board.mismatches + board.pending_overlaps.size();
    $display("Covered %0d candidates over %0d reference settings and %0d register writes.",
             sent, settings, writes);
    $display("Results checked: %0d, %0d with an overlap (patch 0/1/2: %0d/%0d/%0d).",
             board.checked, board.hits, board.patch_hits[0], board.patch_hits[1],
             board.patch_hits[2]);
    if (failed == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
